### rtl/ccc_pkg.sv
// shared types, constants and helper functions of the calendar clock counter
package ccc_pkg;

    // field widths of the counters
    localparam int unsigned SUB_W  = 8;
    localparam int unsigned SEC_W  = 6;
    localparam int unsigned MIN_W  = 6;
    localparam int unsigned HOUR_W = 5;
    localparam int unsigned DAY_W  = 5;
    localparam int unsigned MON_W  = 4;
    localparam int unsigned YEAR_W = 8;

    // counter limits
    localparam logic [6:0] SECS_PER_MIN    = 7'd60;
    localparam logic [6:0] MINS_PER_HOUR   = 7'd60;
    localparam logic [5:0] HOURS_PER_DAY   = 6'd24;
    localparam logic [4:0] MONTH_PAST_LAST = 5'd13;
    localparam logic [MON_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MON_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MON_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MON_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MON_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MON_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MON_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [SUB_W-1:0] TPS_RESET = 8'd100;

    // item kind
    typedef enum logic {
        KIND_TICK = 1'b0,
        KIND_LOAD = 1'b1
    } kind_t;

    // full time and date
    typedef struct packed {
        logic [SUB_W-1:0]  sub;
        logic [SEC_W-1:0]  sec;
        logic [MIN_W-1:0]  min;
        logic [HOUR_W-1:0] hour;
        logic [DAY_W-1:0]  day;
        logic [MON_W-1:0]  mon;
        logic [YEAR_W-1:0] year;
    } clock_state_t;

    // days in a month, leap february when year mod 4 is zero
    function automatic logic [5:0] month_len(input logic [MON_W-1:0] mon,
                                             input logic [YEAR_W-1:0] year);
        logic [5:0] len;
        unique case (mon)
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 6'd30;
            MONTH_FEB: len = (year[1:0] == 2'd0) ? 6'd29 : 6'd28;
            default:   len = 6'd31;
        endcase
        return len;
    endfunction

    // decimal split of a value below 64: {tens[2:0], ones[3:0]}
    function automatic logic [6:0] split_dec(input logic [5:0] v);
        logic [2:0] tens;
        logic [5:0] ones;
        priority if (v >= 6'd60) tens = 3'd6;
        else if (v >= 6'd50)     tens = 3'd5;
        else if (v >= 6'd40)     tens = 3'd4;
        else if (v >= 6'd30)     tens = 3'd3;
        else if (v >= 6'd20)     tens = 3'd2;
        else if (v >= 6'd10)     tens = 3'd1;
        else                     tens = 3'd0;
        ones = v - 6'({3'd0, tens} * 6'd10);
        return {tens, ones[3:0]};
    endfunction

endpackage

### rtl/ccc_tick_if.sv
// input channel: tick or load item with valid/ready handshake
interface ccc_tick_if;
    import ccc_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [YEAR_W-1:0] load_year;
    logic [MON_W-1:0]  load_month;
    logic [DAY_W-1:0]  load_day;
    logic [HOUR_W-1:0] load_hour;
    logic [MIN_W-1:0]  load_minute;
    logic [SEC_W-1:0]  load_second;

    modport source (
        output valid, kind, load_year, load_month, load_day, load_hour,
               load_minute, load_second,
        input  ready
    );

    modport sink (
        input  valid, kind, load_year, load_month, load_day, load_hour,
               load_minute, load_second,
        output ready
    );
endinterface

### rtl/ccc_result_if.sv
// output channel: displayed digits plus full time and date
interface ccc_result_if;
    import ccc_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        hour_tens;
    logic [3:0]        hour_ones;
    logic [2:0]        minute_tens;
    logic [3:0]        minute_ones;
    logic [SEC_W-1:0]  second_now;
    logic [DAY_W-1:0]  day_now;
    logic [MON_W-1:0]  month_now;
    logic [YEAR_W-1:0] year_now;

    modport source (
        output valid, hour_tens, hour_ones, minute_tens, minute_ones,
               second_now, day_now, month_now, year_now,
        input  ready
    );

    modport sink (
        input  valid, hour_tens, hour_ones, minute_tens, minute_ones,
               second_now, day_now, month_now, year_now,
        output ready
    );
endinterface

### rtl/ccc_step.sv
// next-state logic: cascaded tick carry chain and date/time load
module ccc_step (
    input  ccc_pkg::clock_state_t cur,
    input  ccc_pkg::clock_state_t load,
    input  logic                  is_load,
    input  logic [7:0]            tps,
    output ccc_pkg::clock_state_t nxt
);
    import ccc_pkg::*;

    logic [SUB_W:0]  sub_inc;
    logic [SEC_W:0]  sec_inc;
    logic [MIN_W:0]  min_inc;
    logic [HOUR_W:0] hour_inc;
    logic [DAY_W:0]  day_inc;
    logic [MON_W:0]  mon_inc;
    logic            sec_carry;
    logic            min_carry;
    logic            hour_carry;
    logic            day_carry;
    logic            mon_carry;
    logic            year_carry;
    clock_state_t    ticked;

    // carry chain, each stage compares its incremented value with its limit
    always_comb
    begin
        sub_inc    = {1'b0, cur.sub} + 1'b1;
        sec_inc    = {1'b0, cur.sec} + 1'b1;
        min_inc    = {1'b0, cur.min} + 1'b1;
        hour_inc   = {1'b0, cur.hour} + 1'b1;
        day_inc    = {1'b0, cur.day} + 1'b1;
        mon_inc    = {1'b0, cur.mon} + 1'b1;

        sec_carry  = (sub_inc >= {1'b0, tps});
        min_carry  = sec_carry && (sec_inc >= SECS_PER_MIN);
        hour_carry = min_carry && (min_inc >= MINS_PER_HOUR);
        day_carry  = hour_carry && (hour_inc >= HOURS_PER_DAY);
        mon_carry  = day_carry && (day_inc >= month_len(cur.mon, cur.year));
        year_carry = mon_carry && (mon_inc >= MONTH_PAST_LAST);

        ticked.sub  = sec_carry  ? '0 : sub_inc[SUB_W-1:0];
        ticked.sec  = min_carry  ? '0 : (sec_carry  ? sec_inc[SEC_W-1:0]   : cur.sec);
        ticked.min  = hour_carry ? '0 : (min_carry  ? min_inc[MIN_W-1:0]   : cur.min);
        ticked.hour = day_carry  ? '0 : (hour_carry ? hour_inc[HOUR_W-1:0] : cur.hour);
        ticked.day  = mon_carry  ? '0 : (day_carry  ? day_inc[DAY_W-1:0]   : cur.day);
        ticked.mon  = year_carry ? MONTH_JAN
                                 : (mon_carry ? mon_inc[MON_W-1:0] : cur.mon);
        ticked.year = year_carry ? cur.year + 1'b1 : cur.year;
    end

    // load replaces the state, month outside january..december becomes january
    always_comb
    begin
        if (is_load)
        begin
            nxt     = load;
            nxt.sub = '0;
            if (load.mon < MONTH_JAN || load.mon > MONTH_DEC)
            begin
                nxt.mon = MONTH_JAN;
            end
        end
        else
        begin
            nxt = ticked;
        end
    end
endmodule

### rtl/calendar_clock_counter.sv
// calendar clock counter top level: state, result register and handshakes
// a result is registered and appears in the cycle after its item is transferred
// throughput: one item per cycle while no result is pending or the sink takes it; the carry chain is combinational
// the result register frees whenever the sink takes its transfer
// reset (rst_n low, asynchronous): 00:00:00, day 0, january, year 0,
// sub-second count 0, ticks per second 100, no result pending
module calendar_clock_counter (
    input  logic                   clk,
    input  logic                   rst_n,
    ccc_tick_if.sink               tick_ch,
    ccc_result_if.source           result_ch,
    input  logic                   cfg_we,
    input  logic [ccc_pkg::SUB_W-1:0] cfg_wdata
);
    import ccc_pkg::*;

    clock_state_t     state_reg;
    clock_state_t     state_next;
    clock_state_t     load_val;
    logic [SUB_W-1:0] tps_reg;
    logic             out_valid_reg;
    logic [6:0]       hour_dec;
    logic [6:0]       min_dec;
    logic [1:0]       hour_tens_reg;
    logic [3:0]       hour_ones_reg;
    logic [2:0]       minute_tens_reg;
    logic [3:0]       minute_ones_reg;
    logic [SEC_W-1:0] second_reg;
    logic [DAY_W-1:0] day_reg;
    logic [MON_W-1:0] month_reg;
    logic [YEAR_W-1:0] year_reg;
    logic             accept;

    // handshake: take a new item whenever the result register is free or drains
    assign tick_ch.ready = !out_valid_reg || result_ch.ready;
    assign accept        = tick_ch.valid && tick_ch.ready;

    // load value from the input payload
    always_comb
    begin
        load_val.sub  = '0;
        load_val.sec  = tick_ch.load_second;
        load_val.min  = tick_ch.load_minute;
        load_val.hour = tick_ch.load_hour;
        load_val.day  = tick_ch.load_day;
        load_val.mon  = tick_ch.load_month;
        load_val.year = tick_ch.load_year;
    end

    ccc_step u_step (
        .cur     (state_reg),
        .load    (load_val),
        .is_load (kind_t'(tick_ch.kind) == KIND_LOAD),
        .tps     (tps_reg),
        .nxt     (state_next)
    );

    // decimal digits of the new hour and minute
    assign hour_dec = split_dec({1'b0, state_next.hour});
    assign min_dec  = split_dec(state_next.min);

    // ticks per second register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg <= TPS_RESET;
        end
        else if (cfg_we)
        begin
            tps_reg <= cfg_wdata;
        end
    end

    // time and date state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{sub: '0, sec: '0, min: '0, hour: '0, day: '0,
                           mon: MONTH_JAN, year: '0};
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hour_tens_reg   <= hour_dec[5:4];
            hour_ones_reg   <= hour_dec[3:0];
            minute_tens_reg <= min_dec[6:4];
            minute_ones_reg <= min_dec[3:0];
            second_reg      <= state_next.sec;
            day_reg         <= state_next.day;
            month_reg       <= state_next.mon;
            year_reg        <= state_next.year;
        end
    end

    assign result_ch.valid       = out_valid_reg;
    assign result_ch.hour_tens   = hour_tens_reg;
    assign result_ch.hour_ones   = hour_ones_reg;
    assign result_ch.minute_tens = minute_tens_reg;
    assign result_ch.minute_ones = minute_ones_reg;
    assign result_ch.second_now  = second_reg;
    assign result_ch.day_now     = day_reg;
    assign result_ch.month_now   = month_reg;
    assign result_ch.year_now    = year_reg;

    // month counter stays within january..december
    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.mon >= MONTH_JAN && state_reg.mon <= MONTH_DEC)
        else $error("month counter out of range");

    // every transferred item leaves a pending result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("transferred item gave no result");

    // a pending result shows the current date and second
    a_result_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (year_reg == state_reg.year && month_reg == state_reg.mon
                           && day_reg == state_reg.day && second_reg == state_reg.sec))
        else $error("result register out of step with state");

    // a tick below the sub-second limit leaves the seconds alone
    a_no_carry: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind_t'(tick_ch.kind) == KIND_TICK
         && ({1'b0, state_reg.sub} + 1'b1) < {1'b0, tps_reg})
        |=> state_reg.sec == $past(state_reg.sec))
        else $error("seconds moved without a sub-second carry");
endmodule

### bench/calendar_clock_counter_tb.sv
// testbench for the calendar clock counter: directed and random items checked against a predictor
`timescale 1ns / 1ps

module calendar_clock_counter_tb;
    import ccc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;

    // one input item as driven on the tick channel
    typedef struct packed {
        kind_t             kind;
        logic [YEAR_W-1:0] year;
        logic [MON_W-1:0]  month;
        logic [DAY_W-1:0]  day;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
    } clock_item_t;

    // one displayed result
    typedef struct packed {
        logic [1:0]        hour_tens;
        logic [3:0]        hour_ones;
        logic [2:0]        minute_tens;
        logic [3:0]        minute_ones;
        logic [SEC_W-1:0]  second_now;
        logic [DAY_W-1:0]  day_now;
        logic [MON_W-1:0]  month_now;
        logic [YEAR_W-1:0] year_now;
    } clock_face_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [SUB_W-1:0] cfg_wdata;

    ccc_tick_if   tick_ch ();
    ccc_result_if result_ch ();

    calendar_clock_counter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick_ch   (tick_ch),
        .result_ch (result_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // predicted clock state
    logic [SUB_W-1:0]  rate_q;
    logic [SUB_W-1:0]  subsec_q;
    logic [SEC_W-1:0]  second_q;
    logic [MIN_W-1:0]  minute_q;
    logic [HOUR_W-1:0] hour_q;
    logic [DAY_W-1:0]  day_q;
    logic [MON_W-1:0]  month_q;
    logic [YEAR_W-1:0] year_q;

    clock_face_t face_queue [$];

    int unsigned n_sent;
    int unsigned n_loads;
    int unsigned n_results;
    int unsigned n_rates;
    int unsigned n_fail;
    int unsigned cycle_cnt;
    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // receiver stalls at random
    always @(posedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    function automatic int unsigned days_in_month(input logic [MON_W-1:0] m,
                                                  input logic [YEAR_W-1:0] y);
        case (m)
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 30;
            MONTH_FEB: return ((y % 4) == 0) ? 29 : 28;
            default: return 31;
        endcase
    endfunction

    // one tick through the carry chain
    function automatic void advance_tick();
        int unsigned nxt;
        nxt = subsec_q + 1;
        if (nxt < rate_q)
        begin
            subsec_q = nxt[SUB_W-1:0];
            return;
        end
        subsec_q = '0;
        nxt = second_q + 1;
        if (nxt < 60)
        begin
            second_q = nxt[SEC_W-1:0];
            return;
        end
        second_q = '0;
        nxt = minute_q + 1;
        if (nxt < 60)
        begin
            minute_q = nxt[MIN_W-1:0];
            return;
        end
        minute_q = '0;
        nxt = hour_q + 1;
        if (nxt < 24)
        begin
            hour_q = nxt[HOUR_W-1:0];
            return;
        end
        hour_q = '0;
        // day, month and year carry
        nxt = day_q + 1;
        if (nxt >= days_in_month(month_q, year_q))
        begin
            nxt = 0;
            if (month_q >= MONTH_DEC)
            begin
                month_q = MONTH_JAN;
                year_q  = year_q + 1'b1;
            end
            else
                month_q = month_q + 1'b1;
        end
        day_q = nxt[DAY_W-1:0];
    endfunction

    function automatic void apply_item(input clock_item_t it);
        if (it.kind == KIND_LOAD)
        begin
            month_q  = (it.month < MONTH_JAN || it.month > MONTH_DEC) ? MONTH_JAN : it.month;
            year_q   = it.year;
            day_q    = it.day;
            hour_q   = it.hour;
            minute_q = it.minute;
            second_q = it.second;
            subsec_q = '0;
        end
        else
            advance_tick();
    endfunction

    function automatic clock_face_t predicted_face();
        clock_face_t f;
        f.hour_tens   = 2'(hour_q / 10);
        f.hour_ones   = 4'(hour_q % 10);
        f.minute_tens = 3'(minute_q / 10);
        f.minute_ones = 4'(minute_q % 10);
        f.second_now  = second_q;
        f.day_now     = day_q;
        f.month_now   = month_q;
        f.year_now    = year_q;
        return f;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            n_fail++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // predictor and result checker
    always @(posedge clk)
    begin
        clock_face_t want;
        if (!rst_n)
        begin
            rate_q   = TPS_RESET;
            subsec_q = '0;
            second_q = '0;
            minute_q = '0;
            hour_q   = '0;
            day_q    = '0;
            month_q  = MONTH_JAN;
            year_q   = '0;
            face_queue.delete();
        end
        else
        begin
            if (cfg_we)
                rate_q = cfg_wdata;
            // input transfer: predict its result
            if (tick_ch.valid && tick_ch.ready)
            begin
                apply_item('{kind: kind_t'(tick_ch.kind), year: tick_ch.load_year,
                             month: tick_ch.load_month, day: tick_ch.load_day,
                             hour: tick_ch.load_hour, minute: tick_ch.load_minute,
                             second: tick_ch.load_second});
                face_queue.push_back(predicted_face());
            end
            // output transfer: compare with the oldest prediction
            if (result_ch.valid && result_ch.ready)
            begin
                n_results++;
                if (face_queue.size() == 0)
                begin
                    n_fail++;
                    $display("%0t: result with no expectation waiting, actual %0d%0d:%0d%0d:%0d",
                             $time, result_ch.hour_tens, result_ch.hour_ones,
                             result_ch.minute_tens, result_ch.minute_ones,
                             result_ch.second_now);
                end
                else
                begin
                    want = face_queue.pop_front();
                    compare_field("hour_tens", want.hour_tens, result_ch.hour_tens);
                    compare_field("hour_ones", want.hour_ones, result_ch.hour_ones);
                    compare_field("minute_tens", want.minute_tens, result_ch.minute_tens);
                    compare_field("minute_ones", want.minute_ones, result_ch.minute_ones);
                    compare_field("second_now", want.second_now, result_ch.second_now);
                    compare_field("day_now", want.day_now, result_ch.day_now);
                    compare_field("month_now", want.month_now, result_ch.month_now);
                    compare_field("year_now", want.year_now, result_ch.year_now);
                end
            end
        end
    end

    function automatic clock_item_t make_load(input logic [YEAR_W-1:0] y,
                                              input logic [MON_W-1:0] m,
                                              input logic [DAY_W-1:0] d,
                                              input logic [HOUR_W-1:0] h,
                                              input logic [MIN_W-1:0] mi,
                                              input logic [SEC_W-1:0] s);
        return '{kind: KIND_LOAD, year: y, month: m, day: d, hour: h, minute: mi, second: s};
    endfunction

    // load fields of a tick are ignored, so they carry noise
    function automatic clock_item_t make_tick();
        clock_item_t it;
        it      = clock_item_t'($urandom);
        it.kind = KIND_TICK;
        return it;
    endfunction

    // one transfer on the tick channel, with random sender gaps
    task automatic send_item(input clock_item_t it);
        while ($urandom_range(99) < src_idle_pct)
        begin
            tick_ch.valid <= 1'b0;
            @(posedge clk);
        end
        tick_ch.valid       <= 1'b1;
        tick_ch.kind        <= it.kind;
        tick_ch.load_year   <= it.year;
        tick_ch.load_month  <= it.month;
        tick_ch.load_day    <= it.day;
        tick_ch.load_hour   <= it.hour;
        tick_ch.load_minute <= it.minute;
        tick_ch.load_second <= it.second;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        n_sent++;
        if (it.kind == KIND_LOAD)
            n_loads++;
    endtask

    // hold the sender until every result is back
    task automatic drain_results();
        tick_ch.valid <= 1'b0;
        while (n_results < n_sent)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_tick_rate(input logic [SUB_W-1:0] rate);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= rate;
        @(posedge clk);
        cfg_we    <= 1'b0;
        n_rates++;
    endtask

    // display right after reset at the default rate
    task automatic test_reset_display();
        repeat (2) send_item(make_tick());
    endtask

    // loads at the field extremes, bad months and over-range values
    task automatic test_load_ranges();
        send_item(make_load(255, 12, 30, 23, 59, 59));
        send_item(make_load(0, 1, 0, 0, 0, 0));
        send_item(make_load(7, 0, 5, 10, 42, 17));
        send_item(make_load(8, 13, 12, 9, 3, 40));
        send_item(make_load(9, 15, 1, 19, 27, 8));
        send_item(make_load(3, 6, 31, 31, 63, 63));
        send_item(make_tick());
    endtask

    // carries through the whole chain at one tick per second
    task automatic test_calendar_rollover();
        set_tick_rate(1);
        send_item(make_load(255, 12, 30, 23, 59, 59));
        send_item(make_tick());
        send_item(make_load(4, 2, 28, 23, 59, 59));
        send_item(make_tick());
        send_item(make_load(5, 2, 27, 23, 59, 59));
        send_item(make_tick());
        send_item(make_load(6, 4, 29, 23, 59, 59));
        send_item(make_tick());
        send_item(make_load(10, 7, 29, 31, 59, 62));
        send_item(make_tick());
    endtask

    // zero rate: each tick is a full second
    task automatic test_zero_rate();
        set_tick_rate(0);
        repeat (2) send_item(make_tick());
    endtask

    // rate lowered below the sub-second count
    task automatic test_rate_lowered();
        set_tick_rate(5);
        repeat (3) send_item(make_tick());
        set_tick_rate(2);
        send_item(make_tick());
    endtask

    // mostly loads just short of a rollover followed by tick runs
    task automatic run_traffic(input int unsigned n_items);
        int unsigned left;
        int unsigned run;
        int unsigned pick;
        int unsigned len;
        logic [YEAR_W-1:0] y;
        logic [MON_W-1:0]  m;
        left = n_items;
        while (left != 0)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                y   = YEAR_W'($urandom_range(255));
                m   = MON_W'($urandom_range(12, 1));
                len = days_in_month(m, y);
                send_item(make_load(y, m, DAY_W'(len - 1 - $urandom_range(1)),
                                    HOUR_W'($urandom_range(23, 22)),
                                    MIN_W'($urandom_range(59, 57)),
                                    SEC_W'($urandom_range(59, 50))));
                left--;
                run = $urandom_range(30, 1);
            end
            else if (pick < 85)
            begin
                send_item(make_load(YEAR_W'($urandom_range(255)), MON_W'($urandom_range(15)),
                                    DAY_W'($urandom_range(31)), HOUR_W'($urandom_range(31)),
                                    MIN_W'($urandom_range(63)), SEC_W'($urandom_range(63))));
                left--;
                run = $urandom_range(8);
            end
            else
                run = $urandom_range(20, 1);
            if (run > left)
                run = left;
            repeat (run) send_item(make_tick());
            left -= run;
        end
    endtask

    // three idle patterns, two tick rates each
    task automatic test_random_traffic();
        int unsigned src_pct [3];
        int unsigned snk_pct [3];
        src_pct = '{28, 78, 0};
        snk_pct = '{78, 28, 0};
        for (int p = 0; p < 3; p++)
        begin
            src_idle_pct = src_pct[p];
            snk_idle_pct = snk_pct[p];
            case (p)
                0: set_tick_rate(1);
                1: set_tick_rate(2);
                default: set_tick_rate(0);
            endcase
            run_traffic(125);
            case (p)
                0: set_tick_rate(255);
                1: set_tick_rate(SUB_W'($urandom_range(9, 3)));
                default: set_tick_rate(60);
            endcase
            run_traffic(125);
        end
    endtask

    // stimulus sequence
    initial
    begin
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_wdata           <= '0;
        tick_ch.valid       <= 1'b0;
        tick_ch.kind        <= KIND_TICK;
        tick_ch.load_year   <= '0;
        tick_ch.load_month  <= '0;
        tick_ch.load_day    <= '0;
        tick_ch.load_hour   <= '0;
        tick_ch.load_minute <= '0;
        tick_ch.load_second <= '0;
        src_idle_pct = 28;
        snk_idle_pct = 78;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_display();
        test_load_ranges();
        test_calendar_rollover();
        test_zero_rate();
        test_rate_lowered();
        test_random_traffic();

        // wait out the last results
        drain_results();
        repeat (4) @(posedge clk);
        if (face_queue.size() != 0)
        begin
            n_fail++;
            $display("%0t: %0d expected results never arrived", $time, face_queue.size());
        end
        $display("covered %0d items, %0d of them loads, under %0d tick-rate settings",
                 n_sent, n_loads, n_rates + 1);
        $display("checked %0d results, %0d field errors", n_results, n_fail);
        if (n_fail == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
